// ----- hdl/sp3_pkg.sv -----
// ---------------------------------------------------------------------------
// Sub-pixel peak fit package
// Widths, constants and shared types for the 3x3 quadratic peak fit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sp3_pkg;

	localparam int SAMPLE_W = 24;
	localparam int FRAC_W   = 14;
	localparam int OFF_W    = FRAC_W + 2;
	localparam int PEAK_W   = 32;

	// Surface coefficients, scaled by 36, and their pairwise products.
	localparam int COEF_W = 35;
	localparam int WIDE_W = 2 * COEF_W;
	localparam int MUL_W  = COEF_W + WIDE_W;

	// Rounding divider: dividend, divisor and quotient widths.
	localparam int DIV_NW = 108;
	localparam int DIV_DW = 72;
	localparam int DIV_QW = 32;
	localparam int DIV_LAT = DIV_QW + 1;

	// Stages ahead of the dividers, then the divider stages.
	localparam int FRONT_LAT = 7;
	localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT;

	localparam int OFF_ONE = 1 << FRAC_W;

	typedef struct packed {
		logic                ovf;
		logic [DIV_QW-1:0]   quo;
	} div_res_t;

	typedef struct packed {
		logic                       neg_x;
		logic                       neg_y;
		logic                       neg_p;
		logic                       flat;
		logic signed [SAMPLE_W-1:0] centre;
	} side_t;

endpackage

// ----- hdl/subpixel_peak_fit_3x3_unit.sv -----
// ---------------------------------------------------------------------------
// Sub-pixel peak fit, 3x3 quadratic surface
// A transaction passes seven front stages, the 33-stage divider pipelines
// and the output register. One transaction is taken every cycle, since every
// stage is pipelined, except while out_valid is high and out_ready low.
// arst_n clears all valid bits; the datapath registers are not reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module subpixel_peak_fit_3x3_unit import sp3_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] up_left,
	input  logic signed [SAMPLE_W-1:0] up_mid,
	input  logic signed [SAMPLE_W-1:0] up_right,
	input  logic signed [SAMPLE_W-1:0] mid_left,
	input  logic signed [SAMPLE_W-1:0] centre,
	input  logic signed [SAMPLE_W-1:0] mid_right,
	input  logic signed [SAMPLE_W-1:0] low_left,
	input  logic signed [SAMPLE_W-1:0] low_mid,
	input  logic signed [SAMPLE_W-1:0] low_right,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [OFF_W-1:0]    x_offset,
	output logic signed [OFF_W-1:0]    y_offset,
	output logic signed [PEAK_W-1:0]   peak_value,
	output logic                       flat_fit
);

	function automatic logic [WIDE_W-1:0] mag_wide(input logic signed [WIDE_W-1:0] v);
		return v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
	endfunction

	function automatic logic [MUL_W-1:0] mag_mul(input logic signed [MUL_W-1:0] v);
		return v[MUL_W-1] ? MUL_W'(-v) : MUL_W'(v);
	endfunction

	function automatic logic [OFF_W-1:0] off_final(input div_res_t r, input logic neg);
		logic signed [DIV_QW+1:0] one_w;
		logic signed [DIV_QW+1:0] t;
		one_w = (DIV_QW+2)'(OFF_ONE);
		t     = $signed({2'b00, r.quo}) - (one_w <<< 1);
		if (neg || (!r.ovf && t < -one_w)) begin
			return OFF_W'(-OFF_ONE);
		end else if (r.ovf || t > one_w) begin
			return OFF_W'(OFF_ONE);
		end else begin
			return t[OFF_W-1:0];
		end
	endfunction

	function automatic logic [PEAK_W-1:0] peak_final(input div_res_t r, input logic neg);
		if (neg) begin
			if (r.ovf || (r.quo[DIV_QW-1] && |r.quo[DIV_QW-2:0])) begin
				return {1'b1, {(PEAK_W-1){1'b0}}};
			end else begin
				return PEAK_W'(-r.quo);
			end
		end else if (r.ovf || r.quo[DIV_QW-1]) begin
			return {1'b0, {(PEAK_W-1){1'b1}}};
		end else begin
			return PEAK_W'(r.quo);
		end
	endfunction

	logic                en;
	logic [PIPE_LAT-1:0] vld_s;

	logic signed [COEF_W-1:0] smp [9];

	logic signed [COEF_W-1:0]   c_s1, y_s1, yy_s1, x_s1, xy_s1, xx_s1;
	logic signed [SAMPLE_W-1:0] ctr_s1;

	logic signed [WIDE_W-1:0]   p_yyxx_s2, p_xyxy_s2, p_yxy_s2, p_xyy_s2, p_xxy_s2, p_yxx_s2;
	logic signed [COEF_W-1:0]   c_s2, y_s2, x_s2;
	logic signed [SAMPLE_W-1:0] ctr_s2;

	logic signed [WIDE_W-1:0]   det_s3, nx_s3, ny_s3;
	logic signed [COEF_W-1:0]   c_s3, y_s3, x_s3;
	logic signed [SAMPLE_W-1:0] ctr_s3;

	logic signed [WIDE_W-1:0]   det_s4, nx_s4, ny_s4, det_s5, nx_s5, ny_s5;
	logic signed [SAMPLE_W-1:0] ctr_s4, ctr_s5;
	logic signed [MUL_W-1:0]    cdet_s5, yny_s5, xnx_s5;

	logic signed [MUL_W-1:0]    num_s6;
	logic signed [WIDE_W-1:0]   det_s6, nx_s6, ny_s6;
	logic signed [SAMPLE_W-1:0] ctr_s6;

	logic [WIDE_W-1:0] mdet, mnx, mny;
	logic [MUL_W-1:0]  mnum;

	logic [DIV_NW-1:0] xn_s7, yn_s7, pn_s7;
	logic [DIV_DW-1:0] xd_s7, pd_s7;
	side_t             side_s7;
	side_t             side_d [DIV_LAT];

	div_res_t xres, yres, pres;
	side_t    side_o;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	assign smp[0] = COEF_W'(up_left);
	assign smp[1] = COEF_W'(up_mid);
	assign smp[2] = COEF_W'(up_right);
	assign smp[3] = COEF_W'(mid_left);
	assign smp[4] = COEF_W'(centre);
	assign smp[5] = COEF_W'(mid_right);
	assign smp[6] = COEF_W'(low_left);
	assign smp[7] = COEF_W'(low_mid);
	assign smp[8] = COEF_W'(low_right);

	assign mdet = mag_wide(det_s6);
	assign mnx  = mag_wide(nx_s6);
	assign mny  = mag_wide(ny_s6);
	assign mnum = mag_mul(num_s6);

	assign side_o = side_d[DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s     <= {vld_s[PIPE_LAT-2:0], in_valid};
			out_valid <= vld_s[PIPE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1  <= COEF_W'(4) * (COEF_W'(26) * smp[0] - smp[3] + COEF_W'(2) * smp[6]
			         - smp[1] - COEF_W'(19) * smp[4] - COEF_W'(7) * smp[7]
			         + COEF_W'(2) * smp[2] - COEF_W'(7) * smp[5] + COEF_W'(14) * smp[8]);
			y_s1  <= -(COEF_W'(6) * (COEF_W'(8) * smp[0] - COEF_W'(8) * smp[3]
			         + COEF_W'(5) * smp[1] - COEF_W'(8) * smp[4] + COEF_W'(3) * smp[7]
			         + COEF_W'(2) * smp[2] - COEF_W'(8) * smp[5] + COEF_W'(6) * smp[8]));
			yy_s1 <= COEF_W'(6) * (smp[0] - COEF_W'(2) * smp[3] + smp[6] + smp[1]
			         - COEF_W'(2) * smp[4] + smp[7] + smp[2] - COEF_W'(2) * smp[5]
			         + smp[8]);
			x_s1  <= -(COEF_W'(6) * (COEF_W'(8) * smp[0] + COEF_W'(5) * smp[3]
			         + COEF_W'(2) * smp[6] - COEF_W'(8) * smp[1] - COEF_W'(8) * smp[4]
			         - COEF_W'(8) * smp[7] + COEF_W'(3) * smp[5] + COEF_W'(6) * smp[8]));
			xy_s1 <= COEF_W'(9) * (smp[0] - smp[6] - smp[2] + smp[8]);
			xx_s1 <= COEF_W'(6) * (smp[0] + smp[3] + smp[6] - COEF_W'(2) * smp[1]
			         - COEF_W'(2) * smp[4] - COEF_W'(2) * smp[7] + smp[2] + smp[5]
			         + smp[8]);
			ctr_s1 <= centre;

			p_yyxx_s2 <= yy_s1 * xx_s1;
			p_xyxy_s2 <= xy_s1 * xy_s1;
			p_yxy_s2  <= y_s1 * xy_s1;
			p_xyy_s2  <= x_s1 * yy_s1;
			p_xxy_s2  <= x_s1 * xy_s1;
			p_yxx_s2  <= y_s1 * xx_s1;
			c_s2      <= c_s1;
			y_s2      <= y_s1;
			x_s2      <= x_s1;
			ctr_s2    <= ctr_s1;

			det_s3 <= (p_yyxx_s2 <<< 2) - p_xyxy_s2;
			nx_s3  <= p_yxy_s2 - (p_xyy_s2 <<< 1);
			ny_s3  <= p_xxy_s2 - (p_yxx_s2 <<< 1);
			c_s3   <= c_s2;
			y_s3   <= y_s2;
			x_s3   <= x_s2;
			ctr_s3 <= ctr_s2;

			det_s4 <= det_s3;
			nx_s4  <= nx_s3;
			ny_s4  <= ny_s3;
			ctr_s4 <= ctr_s3;
			det_s5 <= det_s4;
			nx_s5  <= nx_s4;
			ny_s5  <= ny_s4;
			ctr_s5 <= ctr_s4;

			// The cross terms always sum to an even value, so the halving is exact.
			num_s6 <= cdet_s5 + ((yny_s5 + xnx_s5) >>> 1);
			det_s6 <= det_s5;
			nx_s6  <= nx_s5;
			ny_s6  <= ny_s5;
			ctr_s6 <= ctr_s5;

			xn_s7 <= (DIV_NW'(mnx) << (FRAC_W + 1)) + DIV_NW'(mdet);
			yn_s7 <= (DIV_NW'(mny) << (FRAC_W + 1)) + DIV_NW'(mdet);
			xd_s7 <= DIV_DW'(mdet) << 1;
			pn_s7 <= (DIV_NW'(mnum) << 1) + (DIV_NW'(mdet) << 5) + (DIV_NW'(mdet) << 2);
			pd_s7 <= (DIV_DW'(mdet) << 6) + (DIV_DW'(mdet) << 3);
			side_s7.neg_x  <= nx_s6[WIDE_W-1] ^ det_s6[WIDE_W-1];
			side_s7.neg_y  <= ny_s6[WIDE_W-1] ^ det_s6[WIDE_W-1];
			side_s7.neg_p  <= num_s6[MUL_W-1] ^ det_s6[WIDE_W-1];
			side_s7.flat   <= det_s6 == '0;
			side_s7.centre <= ctr_s6;

			side_d[0] <= side_s7;
			for (int k = 1; k < DIV_LAT; k++) begin
				side_d[k] <= side_d[k-1];
			end

			if (side_o.flat) begin
				x_offset   <= '0;
				y_offset   <= '0;
				peak_value <= PEAK_W'(side_o.centre);
			end else begin
				x_offset   <= off_final(xres, side_o.neg_x);
				y_offset   <= off_final(yres, side_o.neg_y);
				peak_value <= peak_final(pres, side_o.neg_p);
			end
			flat_fit <= side_o.flat;
		end
	end

	sp3_mul u_mul_cdet (.clk(clk), .en(en), .a(c_s3), .b(det_s3), .p(cdet_s5));
	sp3_mul u_mul_yny  (.clk(clk), .en(en), .a(y_s3), .b(ny_s3),  .p(yny_s5));
	sp3_mul u_mul_xnx  (.clk(clk), .en(en), .a(x_s3), .b(nx_s3),  .p(xnx_s5));

	sp3_div u_div_x (.clk(clk), .en(en), .num(xn_s7), .den(xd_s7), .res(xres));
	sp3_div u_div_y (.clk(clk), .en(en), .num(yn_s7), .den(xd_s7), .res(yres));
	sp3_div u_div_p (.clk(clk), .en(en), .num(pn_s7), .den(pd_s7), .res(pres));

endmodule

// ----- hdl/sp3_mul.sv -----
// ---------------------------------------------------------------------------
// Wide signed multiplier
// Two-stage product of a coefficient and a double-width operand, built
// from two half-width partial products that are summed in the second stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sp3_mul import sp3_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [COEF_W-1:0] a,
	input  logic signed [WIDE_W-1:0] b,
	output logic signed [MUL_W-1:0]  p
);

	logic signed [WIDE_W:0]   plo_s1;
	logic signed [WIDE_W-1:0] phi_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s1 <= a * $signed({1'b0, b[COEF_W-1:0]});
			phi_s1 <= a * $signed(b[WIDE_W-1:COEF_W]);
			p      <= $signed({phi_s1, {COEF_W{1'b0}}})
			          + $signed({{(MUL_W-WIDE_W-1){plo_s1[WIDE_W]}}, plo_s1});
		end
	end

endmodule

// ----- hdl/sp3_div.sv -----
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned division with one quotient bit per stage and an overflow flag
// for quotients that do not fit the quotient width.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sp3_div import sp3_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output div_res_t          res
);

	logic [DIV_DW-1:0] rem_s [DIV_QW];
	logic [DIV_DW-1:0] den_s [DIV_QW];
	logic [DIV_QW-1:0] lo_s  [DIV_QW];
	logic [DIV_QW-1:0] quo_s [DIV_QW+1];
	logic [DIV_QW:0]   ovf_s;
	logic [DIV_DW+1:0] trial [DIV_QW];
	logic              ovf_in;

	assign ovf_in = num[DIV_NW-1:DIV_QW] >= {{(DIV_NW-DIV_QW-DIV_DW){1'b0}}, den};

	always_comb begin
		for (int k = 0; k < DIV_QW; k++) begin
			trial[k] = {1'b0, rem_s[k], lo_s[k][DIV_QW-1]} - {2'b00, den_s[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= ovf_in ? '0 : num[DIV_QW+DIV_DW-1:DIV_QW];
			den_s[0] <= den;
			lo_s[0]  <= num[DIV_QW-1:0];
			quo_s[0] <= '0;
			ovf_s[0] <= ovf_in;
			for (int k = 0; k < DIV_QW; k++) begin
				quo_s[k+1] <= {quo_s[k][DIV_QW-2:0], ~trial[k][DIV_DW+1]};
				ovf_s[k+1] <= ovf_s[k];
			end
			for (int k = 0; k < DIV_QW - 1; k++) begin
				rem_s[k+1] <= trial[k][DIV_DW+1] ?
				              {rem_s[k][DIV_DW-2:0], lo_s[k][DIV_QW-1]} :
				              trial[k][DIV_DW-1:0];
				den_s[k+1] <= den_s[k];
				lo_s[k+1]  <= {lo_s[k][DIV_QW-2:0], 1'b0};
			end
		end
	end

	assign res.ovf = ovf_s[DIV_QW];
	assign res.quo = quo_s[DIV_QW];

endmodule
